// ----- hw/rtl/radial_dead_zone_stick_filter_macros.svh -----
// assertion helpers for the radial dead-zone filter
`ifndef RADIAL_DEAD_ZONE_STICK_FILTER_MACROS_SVH
`define RADIAL_DEAD_ZONE_STICK_FILTER_MACROS_SVH

// same-cycle implication, off during reset
`define RDZ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdz check failed");

// next-cycle implication, off during reset
`define RDZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdz check failed");

// next-cycle implication that also holds across reset
`define RDZ_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rdz reset check failed");

`endif

// ----- hw/rtl/rdz_pkg.sv -----
package rdz_pkg;
  // register widths and reset values
  localparam int DZ_W  = 15;
  localparam int MX_W  = 16;
  localparam int CFG_W = 16;
  localparam int OUT_W = 16;
  // quotient magnitude bits, full scale is 2**Q_W - 1
  localparam int Q_W   = 15;
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd8000;
  localparam logic [MX_W-1:0] MX_RESET = 16'd30000;

  // register indexes
  typedef enum logic [0:0] {
    REG_DEAD_ZONE = 1'b0,
    REG_MAX_VALUE = 1'b1
  } cfg_idx_t;
endpackage

// ----- hw/rtl/rdz_sqrt_cell.sv -----
// one digit of the restoring square root, two radicand bits per cell
module rdz_sqrt_cell #(
  parameter int AW  = 16,
  parameter int IDX = 0,
  parameter int SW  = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [2*AW-1:0] rad_i,
  input  logic [AW+1:0]   rem_i,
  input  logic [AW-1:0]   root_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [2*AW-1:0] rad_o,
  output logic [AW+1:0]   rem_o,
  output logic [AW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);
  logic            vld_r;
  logic [2*AW-1:0] rad_r;
  logic [AW+1:0]   rem_r, rem_nxt, rem_sh, trial;
  logic [AW-1:0]   root_r, root_nxt;
  logic [SW-1:0]   side_r;

  // bring down the next bit pair and try the next root bit
  always_comb begin
    rem_sh = {rem_i[AW-1:0], rad_i[2*IDX+1], rad_i[2*IDX]};
    trial  = {root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[AW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[AW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;
endmodule

// ----- hw/rtl/rdz_div_cell.sv -----
// one quotient bit of the restoring division, for both axes at once
module rdz_div_cell #(
  parameter int NW = 47,
  parameter int DW = 32,
  parameter int K  = 0,
  parameter int SW = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic [NW-1:0]           nx_i,
  input  logic [NW-1:0]           ny_i,
  input  logic [DW-1:0]           d_i,
  input  logic [rdz_pkg::Q_W-1:0] qx_i,
  input  logic [rdz_pkg::Q_W-1:0] qy_i,
  input  logic [SW-1:0]           side_i,
  output logic                    vld_o,
  output logic [NW-1:0]           nx_o,
  output logic [NW-1:0]           ny_o,
  output logic [DW-1:0]           d_o,
  output logic [rdz_pkg::Q_W-1:0] qx_o,
  output logic [rdz_pkg::Q_W-1:0] qy_o,
  output logic [SW-1:0]           side_o
);
  import rdz_pkg::*;

  logic           vld_r;
  logic [NW-1:0]  nx_r, ny_r, dk;
  logic [DW-1:0]  d_r;
  logic [Q_W-1:0] qx_r, qy_r;
  logic [SW-1:0]  side_r;
  logic           gex, gey;

  // compare against the divisor shifted to this bit weight
  always_comb begin
    dk  = NW'(d_i) << K;
    gex = nx_i >= dk;
    gey = ny_i >= dk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= gex ? nx_i - dk : nx_i;
      ny_r   <= gey ? ny_i - dk : ny_i;
      qx_r   <= {qx_i[Q_W-2:0], gex};
      qy_r   <= {qy_i[Q_W-2:0], gey};
      d_r    <= d_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign nx_o   = nx_r;
  assign ny_o   = ny_r;
  assign d_o    = d_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;
  assign side_o = side_r;
endmodule

// ----- hw/rtl/radial_dead_zone_stick_filter.sv -----
// channel  | dir | payload
// in_      | in  | tdata: x_in, y_in (AXIS_BITS each, signed)
// out_     | out | tdata: x_out, y_out (16 bits each, signed Q1.15)
// cfg_     | in  | wr, addr (0 dead_zone, 1 max_value), wdata
// one sample per clock unless the output stalls; the pipe holds the square root
// cell row (one cell per root bit) and the divider row (one cell per quotient bit).
// rst_n is synchronous and empties the pipe. a stalled output holds the whole pipe;
// in_tready is high when out_tready is high or the output register is empty.
module radial_dead_zone_stick_filter #(
  parameter int AXIS_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // x_in [AXIS_BITS-1:0], y_in [2*AXIS_BITS-1:AXIS_BITS], zero pad above
  input  logic [((2*AXIS_BITS+7)/8)*8-1:0] in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // x_out [15:0], y_out [31:16]
  output logic [2*rdz_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_wr,
  input  logic                       cfg_addr,
  input  logic [rdz_pkg::CFG_W-1:0]  cfg_wdata
);
  import rdz_pkg::*;

  localparam int A    = AXIS_BITS;
  localparam int MW   = A + 15;              // magnitude times full scale
  localparam int NW   = A + 31;              // numerator width
  localparam int DW   = A + 16;              // divisor width
  localparam int CW   = ((A > MX_W) ? A : MX_W) + 1;
  localparam int SSW  = 2 + 2 * MW;          // sideband through the root row
  localparam int DSW  = 3;                   // sideband through the divider

  logic adv;
  logic [DZ_W-1:0] dz_r;
  logic [MX_W-1:0] mx_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
      mx_r <= MX_RESET;
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_DEAD_ZONE: dz_r <= cfg_wdata[DZ_W-1:0];
        REG_MAX_VALUE: mx_r <= cfg_wdata[MX_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe moves whenever the output register is free or being drained
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 0: magnitudes and signs
  logic [A-1:0] xi, yi, ax_r, ay_r;
  logic         sx_r, sy_r, v0_r;
  assign xi = in_tdata[A-1:0];
  assign yi = in_tdata[2*A-1:A];

  // stage 1: squares and magnitude times full scale
  logic [2*A-1:0] sqx_r, sqy_r;
  logic [MW-1:0]  mx32_r, my32_r;
  logic           sx1_r, sy1_r, v1_r;

  // stage 2: sum of squares
  logic [2*A-1:0] rad_r;
  logic [SSW-1:0] side2_r;
  logic           v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r    <= xi[A-1];
      sy_r    <= yi[A-1];
      ax_r    <= xi[A-1] ? (~xi + 1'b1) : xi;
      ay_r    <= yi[A-1] ? (~yi + 1'b1) : yi;
      sqx_r   <= (2*A)'(ax_r) * (2*A)'(ax_r);
      sqy_r   <= (2*A)'(ay_r) * (2*A)'(ay_r);
      mx32_r  <= (MW'(ax_r) << 15) - MW'(ax_r);
      my32_r  <= (MW'(ay_r) << 15) - MW'(ay_r);
      sx1_r   <= sx_r;
      sy1_r   <= sy_r;
      rad_r   <= sqx_r + sqy_r;
      side2_r <= {sx1_r, sy1_r, mx32_r, my32_r};
    end
  end

  // square root row, most significant root bit first
  logic             sv   [0:A];
  logic [2*A-1:0]   srad [0:A];
  logic [A+1:0]     srem [0:A];
  logic [A-1:0]     sroot[0:A];
  logic [SSW-1:0]   sside[0:A];

  assign sv[0]    = v2_r;
  assign srad[0]  = rad_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = side2_r;

  for (genvar j = 0; j < A; j++) begin : g_sqrt
    rdz_sqrt_cell #(.AW(A), .IDX(A - 1 - j), .SW(SSW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (sv[j]),
      .rad_i  (srad[j]),
      .rem_i  (srem[j]),
      .root_i (sroot[j]),
      .side_i (sside[j]),
      .vld_o  (sv[j+1]),
      .rad_o  (srad[j+1]),
      .rem_o  (srem[j+1]),
      .root_o (sroot[j+1]),
      .side_o (sside[j+1])
    );
  end

  // stage 3: clamped fraction num/den
  logic [CW-1:0]   lc, dzc, mxc, ldiff, mdiff;
  logic            zero_c, full_c;
  logic [MX_W-1:0] num_r, den_r;
  logic [A-1:0]    len_r;
  logic            zero3_r, v3_r;
  logic [SSW-1:0]  side3_r;

  always_comb begin
    lc     = CW'(sroot[A]);
    dzc    = CW'(dz_r);
    mxc    = CW'(mx_r);
    ldiff  = lc - dzc;
    mdiff  = mxc - dzc;
    zero_c = (lc < dzc) || (sroot[A] == '0);
    full_c = (mxc <= dzc) || (ldiff >= mdiff);
  end

  // stage 4: numerators and divisor
  logic [NW-1:0] nx4_r, ny4_r;
  logic [DW-1:0] d4_r;
  logic [DSW-1:0] side4_r;
  logic           v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v3_r <= sv[A];
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r   <= full_c ? MX_W'(1) : ldiff[MX_W-1:0];
      den_r   <= full_c ? MX_W'(1) : mdiff[MX_W-1:0];
      len_r   <= sroot[A];
      zero3_r <= zero_c;
      side3_r <= sside[A];
      nx4_r   <= NW'(side3_r[2*MW-1:MW]) * NW'(num_r);
      ny4_r   <= NW'(side3_r[MW-1:0]) * NW'(num_r);
      d4_r    <= DW'(den_r) * DW'(len_r);
      side4_r <= {zero3_r, side3_r[SSW-1], side3_r[SSW-2]};
    end
  end

  // divider row, most significant quotient bit first
  logic           dv   [0:Q_W];
  logic [NW-1:0]  dnx  [0:Q_W];
  logic [NW-1:0]  dny  [0:Q_W];
  logic [DW-1:0]  dd   [0:Q_W];
  logic [Q_W-1:0] dqx  [0:Q_W];
  logic [Q_W-1:0] dqy  [0:Q_W];
  logic [DSW-1:0] dside[0:Q_W];

  assign dv[0]    = v4_r;
  assign dnx[0]   = nx4_r;
  assign dny[0]   = ny4_r;
  assign dd[0]    = d4_r;
  assign dqx[0]   = '0;
  assign dqy[0]   = '0;
  assign dside[0] = side4_r;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    rdz_div_cell #(.NW(NW), .DW(DW), .K(Q_W - 1 - k), .SW(DSW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (dv[k]),
      .nx_i   (dnx[k]),
      .ny_i   (dny[k]),
      .d_i    (dd[k]),
      .qx_i   (dqx[k]),
      .qy_i   (dqy[k]),
      .side_i (dside[k]),
      .vld_o  (dv[k+1]),
      .nx_o   (dnx[k+1]),
      .ny_o   (dny[k+1]),
      .d_o    (dd[k+1]),
      .qx_o   (dqx[k+1]),
      .qy_o   (dqy[k+1]),
      .side_o (dside[k+1])
    );
  end

  // output register: sign and dead-zone zeroing
  logic [OUT_W-1:0] qxe, qye, xo_r, yo_r;
  logic             ov_r;
  assign qxe = {1'b0, dqx[Q_W]};
  assign qye = {1'b0, dqy[Q_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xo_r <= dside[Q_W][2] ? '0 : (dside[Q_W][1] ? (~qxe + 1'b1) : qxe);
      yo_r <= dside[Q_W][2] ? '0 : (dside[Q_W][0] ? (~qye + 1'b1) : qye);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {yo_r, xo_r};
endmodule

// ----- hw/rtl/rdz_checker.sv -----
`include "radial_dead_zone_stick_filter_macros.svh"

// port-level checks for the radial dead-zone filter
module rdz_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [2*rdz_pkg::OUT_W-1:0] out_tdata
);
  // stalled result holds
  `RDZ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // results saturate short of the most negative code
  `RDZ_ASSERT_NOW(a_sat, out_tvalid, out_tdata[15:0] != 16'h8000 && out_tdata[31:16] != 16'h8000)
  // an empty output register never blocks the input
  `RDZ_ASSERT_NOW(a_ready, !out_tvalid, in_tready)
  // reset empties the pipe
  `RDZ_ASSERT_RST(a_rst, !rst_n, !out_tvalid)
endmodule

bind radial_dead_zone_stick_filter rdz_checker u_rdz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/sv/stick_filter_checker.sv -----
// watches the sample and result streams, predicts each result and compares
module stick_filter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_wr,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);
  import rdz_pkg::*;

  logic [DZ_W-1:0] dz_copy;
  logic [MX_W-1:0] mx_copy;
  logic [31:0]     expected_q[$];

  // floor of the square root, one root bit per pass
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one axis scaled by num/den over the length, truncated and saturated
  function automatic logic [15:0] scale_axis(longint c, longint unsigned num,
                                             longint unsigned den, longint unsigned len);
    longint unsigned m;
    longint unsigned q;
    m = (c < 0) ? longint'(-c) : c;
    q = (m * 32767 * num) / (den * len);
    if (q > 32767) q = 32767;
    return (c < 0) ? 16'(-q) : 16'(q);
  endfunction

  // expected {y_out, x_out} for one sample
  function automatic logic [31:0] filter_stick(logic [31:0] d, logic [DZ_W-1:0] dz,
                                               logic [MX_W-1:0] mx);
    longint xi;
    longint yi;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned len;
    longint unsigned num;
    longint unsigned den;
    xi = longint'($signed(d[15:0]));
    yi = longint'($signed(d[31:16]));
    ax = (xi < 0) ? -xi : xi;
    ay = (yi < 0) ? -yi : yi;
    len = root_floor(ax * ax + ay * ay);
    if (len < dz || len == 0) return 32'd0;
    if (mx <= dz) begin
      num = 1;
      den = 1;
    end else begin
      num = len - dz;
      den = mx - dz;
      if (num >= den) begin
        num = 1;
        den = 1;
      end
    end
    return {scale_axis(yi, num, den, len), scale_axis(xi, num, den, len)};
  endfunction

  // register copy
  always @(posedge clk) begin
    if (!rst_n) begin
      dz_copy <= DZ_RESET;
      mx_copy <= MX_RESET;
    end else if (cfg_wr) begin
      if (cfg_idx_t'(cfg_addr) == REG_DEAD_ZONE) dz_copy <= cfg_wdata[DZ_W-1:0];
      else mx_copy <= cfg_wdata[MX_W-1:0];
    end
  end

  // predict on sample transfer, compare on result transfer
  always @(posedge clk) begin
    logic [31:0] exp_d;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_q.push_back(filter_stick(in_tdata, dz_copy, mx_copy));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          mismatches++;
        end else begin
          exp_d = expected_q.pop_front();
          if (out_tdata[15:0] !== exp_d[15:0]) begin
            $error("x_out expected %0d actual %0d", $signed(exp_d[15:0]),
                   $signed(out_tdata[15:0]));
            mismatches++;
          end
          if (out_tdata[31:16] !== exp_d[31:16]) begin
            $error("y_out expected %0d actual %0d", $signed(exp_d[31:16]),
                   $signed(out_tdata[31:16]));
            mismatches++;
          end
        end
      end
    end
    // results still owed
    pending = expected_q.size();
  end

  initial begin
    mismatches = 0;
    results_seen = 0;
    pending = 0;
  end
endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import rdz_pkg::*;

  localparam int LATENCY = 16 + 21;
  localparam int IDLE_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_wr;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;
  int          mismatches;
  int          pending;
  int          results_seen;
  int          stall_mode;
  int          burst_left;
  int          idle_cycles;
  int          samples_sent;
  int          cfg_writes;

  radial_dead_zone_stick_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  stick_filter_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
  );

  always #6 clk = ~clk;

  // receiver stall pattern, changed per phase
  always @(posedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) < 7);
      2: out_tready <= ($urandom_range(0, 2) == 0);
      default: out_tready <= ($urandom_range(0, 19) != 0);
    endcase
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one sample transfer, sender bursts with gaps
  task automatic send_sample(logic [15:0] xs, logic [15:0] ys);
    in_tdata <= {ys, xs};
    in_tvalid <= 1'b1;
    @(posedge clk iff in_tready);
    samples_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // let the pipe empty before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // one register write with a one-cycle strobe
  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_wr <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // random sample mix: full range, near the rings, axes and corners
  task automatic random_samples(int count);
    logic [15:0] xs;
    logic [15:0] ys;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        xs = 16'($urandom);
        ys = 16'($urandom);
      end else if (pick < 8) begin
        xs = 16'($signed($urandom_range(0, 24000)) - 12000);
        ys = 16'($signed($urandom_range(0, 24000)) - 12000);
      end else begin
        xs = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        ys = $urandom_range(0, 1) ? 16'h0000 : 16'(-$signed(xs));
        if ($urandom_range(0, 1)) {xs, ys} = {ys, xs};
      end
      send_sample(xs, ys);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr = 1'b0;
    cfg_addr = 1'b0;
    cfg_wdata = '0;
    stall_mode = 0;
    burst_left = 5;
    idle_cycles = 0;
    samples_sent = 0;
    cfg_writes = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, extremes, inside, ramp and beyond
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h0000, 16'h7fff);
    send_sample(16'd7999, 16'h0000);
    send_sample(16'd8000, 16'h0000);
    send_sample(16'h0000, 16'(-8001));
    send_sample(16'd19000, 16'(-3000));
    send_sample(16'd30000, 16'h0000);
    send_sample(16'(-21213), 16'd21213);
    send_sample(16'h0001, 16'hffff);
    drain();

    // zero dead zone, zero length and the widest ramp
    write_reg(REG_DEAD_ZONE, 16'h8000);
    write_reg(REG_MAX_VALUE, 16'hffff);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h8001);
    drain();

    // max not above the dead zone, then max of zero
    write_reg(REG_DEAD_ZONE, 16'h7fff);
    write_reg(REG_MAX_VALUE, 16'd100);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h0000);
    send_sample(16'd100, 16'd100);
    drain();
    write_reg(REG_DEAD_ZONE, 16'd5);
    write_reg(REG_MAX_VALUE, 16'h0000);
    send_sample(16'd3, 16'd4);
    send_sample(16'hfffd, 16'hfffc);
    drain();

    // random phases across settings and stall patterns
    for (int ph = 0; ph < 7; ph++) begin
      stall_mode = ph % 4;
      case (ph)
        0: begin
          write_reg(REG_DEAD_ZONE, 16'd8000);
          write_reg(REG_MAX_VALUE, 16'd30000);
        end
        1: begin
          write_reg(REG_DEAD_ZONE, 16'd0);
          write_reg(REG_MAX_VALUE, 16'd1);
        end
        2: begin
          write_reg(REG_DEAD_ZONE, 16'd0);
          write_reg(REG_MAX_VALUE, 16'd46341);
        end
        3: begin
          write_reg(REG_DEAD_ZONE, 16'h7fff);
          write_reg(REG_MAX_VALUE, 16'd46341);
        end
        default: begin
          write_reg(REG_DEAD_ZONE, 16'($urandom_range(0, 65535)));
          write_reg(REG_MAX_VALUE, 16'($urandom_range(0, 65535)));
        end
      endcase
      random_samples(245);
      drain();
    end

    stall_mode = 0;
    $display("sent %0d samples, checked %0d results over %0d register writes",
             samples_sent, results_seen, cfg_writes);
    $display("covered dead zone, ramp, full scale, degenerate max and stalls");
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/rdz_pkg.sv
hw/rtl/rdz_sqrt_cell.sv
hw/rtl/rdz_div_cell.sv
hw/rtl/radial_dead_zone_stick_filter.sv
hw/rtl/rdz_checker.sv
tb/sv/stick_filter_checker.sv
tb/sv/testbench.sv
